// ----- hdl/i2c_mrr_pkg.sv -----
package i2c_mrr_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int LIM_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   typedef logic [TIMER_BITS-1:0] timer_type;

   typedef enum logic [1:0] {
      CSR_ENABLE         = 2'd0,
      CSR_HALF_BIT_TICKS = 2'd1,
      CSR_STRETCH_TICKS  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      P_IDLE      = 5'd0,
      P_START_A   = 5'd1,
      P_START_B   = 5'd2,
      P_TX_LOW    = 5'd3,
      P_TX_WAIT   = 5'd4,
      P_TX_HIGH   = 5'd5,
      P_TACK_LOW  = 5'd6,
      P_TACK_WAIT = 5'd7,
      P_TACK_HIGH = 5'd8,
      P_RX_LOW    = 5'd9,
      P_RX_WAIT   = 5'd10,
      P_RX_HIGH   = 5'd11,
      P_RACK_LOW  = 5'd12,
      P_RACK_WAIT = 5'd13,
      P_RACK_HIGH = 5'd14,
      P_STOP_A    = 5'd15,
      P_STOP_WAIT = 5'd16,
      P_STOP_B    = 5'd17,
      P_STOP_C    = 5'd18
   } phase_type;

   typedef enum logic [1:0] {
      STAGE_ADDR_WRITE = 2'd0,
      STAGE_REG_BYTE   = 2'd1,
      STAGE_READ       = 2'd2
   } stage_type;

   localparam logic OP_PROBE    = 1'b0;
   localparam logic OP_REG_READ = 1'b1;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] byte_data;
      logic       done_res;
      logic       success;
   } rsp_type;

   // Limit as seen by a timer: saturated to the timer range, zero taken as one.
   function automatic timer_type limit_of(input logic [CFG_BITS-1:0] value);
      logic [LIM_BITS-1:0] wide;
      logic [LIM_BITS-1:0] top;
      begin
         wide = LIM_BITS'(value);
         top  = LIM_BITS'({TIMER_BITS{1'b1}});
         if (wide > top) begin
            wide = top;
         end
         if (wide == '0) begin
            wide = LIM_BITS'(1);
         end
         return timer_type'(wide);
      end
   endfunction

endpackage

// ----- hdl/i2c_master_register_read.sv -----
// Open-drain I2C master that runs a probe or a register read, one item per SCL
// sampling tick. Every accepted item yields exactly one result item, captured at
// the accepting edge and presented on the next cycle unless an earlier result is
// still stalled; a new item is taken every cycle while req_stall is low. A two-entry output
// buffer (result register plus skid register) lets one item be accepted while a
// result is stalled, and req_stall rises only when both entries are full.
// Configuration writes are accepted every cycle (csr_ready is always high) and
// take effect for the next accepted item.
module i2c_master_register_read (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd_valid,
   input  logic        req_opcode,
   input  logic [6:0]  req_target_address,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_read_length,
   input  logic        req_scl_in,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_drive_low,
   output logic        rsp_sda_drive_low,
   output logic        rsp_busy_res,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_byte_data,
   output logic        rsp_done_res,
   output logic        rsp_success
);

   logic                  enable_ff;
   logic [15:0]           half_ticks_ff;
   logic [15:0]           stretch_ticks_ff;

   i2c_mrr_pkg::phase_type phase_ff, phase_in;
   i2c_mrr_pkg::stage_type stage_ff, stage_in;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [7:0]             bytes_left_ff, bytes_left_in;
   i2c_mrr_pkg::timer_type half_timer_ff, half_timer_in;
   i2c_mrr_pkg::timer_type stretch_timer_ff, stretch_timer_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic [6:0]             held_address_ff, held_address_in;
   logic [7:0]             held_register_ff, held_register_in;
   logic                   held_opcode_ff, held_opcode_in;
   logic                   failed_ff, failed_in;
   logic                   scl_low_ff, scl_low_in;
   logic                   sda_low_ff, sda_low_in;

   i2c_mrr_pkg::rsp_type   result;
   i2c_mrr_pkg::rsp_type   out_ff, out_in;
   i2c_mrr_pkg::rsp_type   skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                   accept;
   logic                   drain;

   i2c_mrr_pkg::timer_type half_limit;
   i2c_mrr_pkg::timer_type stretch_limit;
   i2c_mrr_pkg::timer_type half_inc;
   i2c_mrr_pkg::timer_type stretch_inc;
   logic                   half_done;
   logic                   stretch_over;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign drain     = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         half_ticks_ff    <= 16'd5;
         stretch_ticks_ff <= 16'd200;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            i2c_mrr_pkg::CSR_ENABLE:         enable_ff        <= csr_wdata[0];
            i2c_mrr_pkg::CSR_HALF_BIT_TICKS: half_ticks_ff    <= csr_wdata;
            i2c_mrr_pkg::CSR_STRETCH_TICKS:  stretch_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign half_limit    = i2c_mrr_pkg::limit_of(half_ticks_ff);
   assign stretch_limit = i2c_mrr_pkg::limit_of(stretch_ticks_ff);
   assign half_inc      = (half_timer_ff == '1) ? half_timer_ff
                          : half_timer_ff + i2c_mrr_pkg::timer_type'(1);
   assign stretch_inc   = (stretch_timer_ff == '1) ? stretch_timer_ff
                          : stretch_timer_ff + i2c_mrr_pkg::timer_type'(1);
   assign half_done     = half_inc >= half_limit;
   assign stretch_over  = stretch_inc >= stretch_limit;

   always_comb begin
      logic [7:0] addr_byte;
      logic [3:0] next_count;
      logic [7:0] left_dec;

      phase_in         = phase_ff;
      stage_in         = stage_ff;
      bit_count_in     = bit_count_ff;
      bytes_left_in    = bytes_left_ff;
      half_timer_in    = half_timer_ff;
      stretch_timer_in = stretch_timer_ff;
      shift_byte_in    = shift_byte_ff;
      held_address_in  = held_address_ff;
      held_register_in = held_register_ff;
      held_opcode_in   = held_opcode_ff;
      failed_in        = failed_ff;
      scl_low_in       = scl_low_ff;
      sda_low_in       = sda_low_ff;
      result           = '0;

      addr_byte  = {held_address_ff, (stage_ff == i2c_mrr_pkg::STAGE_READ)};
      next_count = bit_count_ff + 4'd1;
      left_dec   = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : bytes_left_ff;

      unique case (phase_ff)
         i2c_mrr_pkg::P_IDLE: begin
            if (req_cmd_valid) begin
               held_opcode_in   = req_opcode;
               held_address_in  = req_target_address;
               held_register_in = req_reg_addr;
               if (!enable_ff || (req_opcode == i2c_mrr_pkg::OP_REG_READ &&
                                  req_read_length == 8'd0)) begin
                  result.done_res = 1'b1;
               end else begin
                  failed_in        = 1'b0;
                  stage_in         = i2c_mrr_pkg::STAGE_ADDR_WRITE;
                  bytes_left_in    = req_read_length;
                  scl_low_in       = 1'b0;
                  sda_low_in       = 1'b0;
                  phase_in         = i2c_mrr_pkg::P_START_A;
                  half_timer_in    = '0;
                  stretch_timer_in = '0;
               end
            end
         end
         i2c_mrr_pkg::P_START_A, i2c_mrr_pkg::P_TX_LOW, i2c_mrr_pkg::P_TACK_LOW,
         i2c_mrr_pkg::P_RX_LOW, i2c_mrr_pkg::P_RACK_LOW, i2c_mrr_pkg::P_STOP_A,
         i2c_mrr_pkg::P_STOP_B: begin
            half_timer_in = half_inc;
            if (half_done) begin
               half_timer_in    = '0;
               stretch_timer_in = '0;
               phase_in         = i2c_mrr_pkg::phase_type'(phase_ff + 5'd1);
               if (phase_ff == i2c_mrr_pkg::P_START_A) begin
                  sda_low_in = 1'b1;
               end else if (phase_ff == i2c_mrr_pkg::P_STOP_B) begin
                  sda_low_in = 1'b0;
               end else begin
                  scl_low_in = 1'b0;
               end
            end
         end
         i2c_mrr_pkg::P_START_B: begin
            half_timer_in = half_inc;
            if (half_done) begin
               scl_low_in       = 1'b1;
               shift_byte_in    = addr_byte;
               bit_count_in     = 4'd0;
               sda_low_in       = !addr_byte[7];
               phase_in         = i2c_mrr_pkg::P_TX_LOW;
               half_timer_in    = '0;
               stretch_timer_in = '0;
            end
         end
         i2c_mrr_pkg::P_TX_WAIT, i2c_mrr_pkg::P_TACK_WAIT, i2c_mrr_pkg::P_RX_WAIT,
         i2c_mrr_pkg::P_RACK_WAIT, i2c_mrr_pkg::P_STOP_WAIT: begin
            if (req_scl_in) begin
               phase_in         = i2c_mrr_pkg::phase_type'(phase_ff + 5'd1);
               half_timer_in    = '0;
               stretch_timer_in = '0;
            end else if (stretch_over) begin
               half_timer_in    = '0;
               stretch_timer_in = '0;
               if (phase_ff == i2c_mrr_pkg::P_STOP_WAIT) begin
                  scl_low_in      = 1'b0;
                  sda_low_in      = 1'b0;
                  phase_in        = i2c_mrr_pkg::P_IDLE;
                  result.done_res = 1'b1;
                  result.success  = !failed_ff;
               end else begin
                  failed_in  = 1'b1;
                  scl_low_in = 1'b1;
                  sda_low_in = 1'b1;
                  phase_in   = i2c_mrr_pkg::P_STOP_A;
               end
            end else begin
               stretch_timer_in = stretch_inc;
            end
         end
         i2c_mrr_pkg::P_TX_HIGH: begin
            half_timer_in = half_inc;
            if (half_done) begin
               scl_low_in       = 1'b1;
               bit_count_in     = next_count;
               half_timer_in    = '0;
               stretch_timer_in = '0;
               if (next_count >= 4'd8) begin
                  sda_low_in = 1'b0;
                  phase_in   = i2c_mrr_pkg::P_TACK_LOW;
               end else begin
                  sda_low_in = !shift_byte_ff[3'd7 - next_count[2:0]];
                  phase_in   = i2c_mrr_pkg::P_TX_LOW;
               end
            end
         end
         i2c_mrr_pkg::P_TACK_HIGH: begin
            half_timer_in = half_inc;
            if (half_done) begin
               scl_low_in       = 1'b1;
               half_timer_in    = '0;
               stretch_timer_in = '0;
               if (req_sda_in || (stage_ff == i2c_mrr_pkg::STAGE_ADDR_WRITE &&
                                  held_opcode_ff == i2c_mrr_pkg::OP_PROBE)) begin
                  failed_in  = failed_ff || req_sda_in;
                  sda_low_in = 1'b1;
                  phase_in   = i2c_mrr_pkg::P_STOP_A;
               end else if (stage_ff == i2c_mrr_pkg::STAGE_ADDR_WRITE) begin
                  stage_in      = i2c_mrr_pkg::STAGE_REG_BYTE;
                  shift_byte_in = held_register_ff;
                  bit_count_in  = 4'd0;
                  sda_low_in    = !held_register_ff[7];
                  phase_in      = i2c_mrr_pkg::P_TX_LOW;
               end else if (stage_ff == i2c_mrr_pkg::STAGE_REG_BYTE) begin
                  stage_in   = i2c_mrr_pkg::STAGE_READ;
                  scl_low_in = 1'b0;
                  sda_low_in = 1'b0;
                  phase_in   = i2c_mrr_pkg::P_START_A;
               end else begin
                  shift_byte_in = 8'd0;
                  bit_count_in  = 4'd0;
                  sda_low_in    = 1'b0;
                  phase_in      = i2c_mrr_pkg::P_RX_LOW;
               end
            end
         end
         i2c_mrr_pkg::P_RX_HIGH: begin
            half_timer_in = half_inc;
            if (half_done) begin
               shift_byte_in    = {shift_byte_ff[6:0], req_sda_in};
               scl_low_in       = 1'b1;
               bit_count_in     = next_count;
               half_timer_in    = '0;
               stretch_timer_in = '0;
               if (next_count >= 4'd8) begin
                  sda_low_in = bytes_left_ff > 8'd1;
                  phase_in   = i2c_mrr_pkg::P_RACK_LOW;
               end else begin
                  phase_in = i2c_mrr_pkg::P_RX_LOW;
               end
            end
         end
         i2c_mrr_pkg::P_RACK_HIGH: begin
            half_timer_in = half_inc;
            if (half_done) begin
               result.byte_valid = 1'b1;
               result.byte_data  = shift_byte_ff;
               bytes_left_in     = left_dec;
               half_timer_in     = '0;
               stretch_timer_in  = '0;
               scl_low_in        = 1'b1;
               if (left_dec == 8'd0) begin
                  sda_low_in = 1'b1;
                  phase_in   = i2c_mrr_pkg::P_STOP_A;
               end else begin
                  shift_byte_in = 8'd0;
                  bit_count_in  = 4'd0;
                  sda_low_in    = 1'b0;
                  phase_in      = i2c_mrr_pkg::P_RX_LOW;
               end
            end
         end
         i2c_mrr_pkg::P_STOP_C: begin
            half_timer_in = half_inc;
            if (half_done) begin
               scl_low_in       = 1'b0;
               sda_low_in       = 1'b0;
               phase_in         = i2c_mrr_pkg::P_IDLE;
               half_timer_in    = '0;
               stretch_timer_in = '0;
               result.done_res  = 1'b1;
               result.success   = !failed_ff;
            end
         end
         default: begin
            scl_low_in       = 1'b0;
            sda_low_in       = 1'b0;
            phase_in         = i2c_mrr_pkg::P_IDLE;
            half_timer_in    = '0;
            stretch_timer_in = '0;
            result.done_res  = 1'b1;
            result.success   = !failed_ff;
         end
      endcase

      result.scl_drive_low = scl_low_in;
      result.sda_drive_low = sda_low_in;
      result.busy_res      = phase_in != i2c_mrr_pkg::P_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= i2c_mrr_pkg::P_IDLE;
         stage_ff         <= i2c_mrr_pkg::STAGE_ADDR_WRITE;
         bit_count_ff     <= '0;
         bytes_left_ff    <= '0;
         half_timer_ff    <= '0;
         stretch_timer_ff <= '0;
         shift_byte_ff    <= '0;
         held_address_ff  <= '0;
         held_register_ff <= '0;
         held_opcode_ff   <= 1'b0;
         failed_ff        <= 1'b0;
         scl_low_ff       <= 1'b0;
         sda_low_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         stage_ff         <= stage_in;
         bit_count_ff     <= bit_count_in;
         bytes_left_ff    <= bytes_left_in;
         half_timer_ff    <= half_timer_in;
         stretch_timer_ff <= stretch_timer_in;
         shift_byte_ff    <= shift_byte_in;
         held_address_ff  <= held_address_in;
         held_register_ff <= held_register_in;
         held_opcode_ff   <= held_opcode_in;
         failed_ff        <= failed_in;
         scl_low_ff       <= scl_low_in;
         sda_low_ff       <= sda_low_in;
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_drive_low = out_ff.scl_drive_low;
   assign rsp_sda_drive_low = out_ff.sda_drive_low;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_byte_valid    = out_ff.byte_valid;
   assign rsp_byte_data     = out_ff.byte_data;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_success       = out_ff.success;

endmodule

// ----- hdl/i2c_mrr_checker.sv -----
module i2c_mrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl_drive_low,
   input logic       rsp_sda_drive_low,
   input logic       rsp_busy_res,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_byte_data,
   input logic       rsp_done_res,
   input logic       rsp_success
);

   // A finished transaction always leaves both lines released and the block idle.
   a_done_releases : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_scl_drive_low &&
                                    !rsp_sda_drive_low)
      else $error("done item with lines still driven or busy");

   a_success_needs_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_done_res)
      else $error("success without done");

   a_byte_while_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_done_res && rsp_busy_res)
      else $error("received byte outside a running transaction");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_data) &&
                                 $stable(rsp_done_res))
      else $error("stalled result item changed");

endmodule

bind i2c_master_register_read i2c_mrr_checker u_i2c_mrr_checker (.*);
